// ----- src/mgm_pkg.sv -----
// Package for the masked Gram matrix block: widths, request and register codes,
// and the control bundle between the sequencer and the MAC unit. No dependencies.
`default_nettype none

package mgm_pkg;

    // Default sizes of the column stores
    localparam int DEFAULT_MAX_VECS = 8;
    localparam int DEFAULT_MAX_LEN  = 256;

    // Field widths
    localparam int REQ_TYPE_W  = 2;
    localparam int VEC_IDX_W   = 3;
    localparam int ELEM_IDX_W  = 8;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int DOT_W       = 48;
    localparam int POS_W       = 3;
    localparam int ADDR_W      = 9;
    localparam int MASK_W      = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_VEC_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VECS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STRIDE = 3'd4;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_X  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_Y  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_COMPUTE = 2'd2;

    // Register reset values
    localparam logic [8:0] RST_VEC_LENGTH = 9'd256;
    localparam logic [3:0] RST_NUM_VECS   = 4'd8;
    localparam logic [7:0] RST_X_MASK     = 8'd255;
    localparam logic [7:0] RST_Y_MASK     = 8'd255;
    localparam logic [6:0] RST_OUT_STRIDE = 7'd8;

    // Sequencer to MAC control
    typedef struct packed {
        logic clear;  // zero the accumulator and flush the product stage
        logic en;     // store read data is valid this cycle
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- src/mgm_if.sv -----
// Handshake channels of the masked Gram matrix block: requests, results and
// configuration writes. Depends on mgm_pkg for field widths.
`default_nettype none

interface mgm_req_if;
    logic                                valid;
    logic                                ready;
    logic [mgm_pkg::REQ_TYPE_W-1:0]      req_type;
    logic [mgm_pkg::VEC_IDX_W-1:0]       vec_index;
    logic [mgm_pkg::ELEM_IDX_W-1:0]      elem_index;
    logic signed [mgm_pkg::ELEM_W-1:0]   elem_value;

    modport source (output valid, req_type, vec_index, elem_index, elem_value, input ready);
    modport sink   (input valid, req_type, vec_index, elem_index, elem_value, output ready);
endinterface

interface mgm_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [mgm_pkg::DOT_W-1:0]    dot_value;
    logic [mgm_pkg::POS_W-1:0]           row_pos;
    logic [mgm_pkg::POS_W-1:0]           col_pos;
    logic [mgm_pkg::ADDR_W-1:0]          out_addr;
    logic                                last_one;

    modport source (output valid, dot_value, row_pos, col_pos, out_addr, last_one, input ready);
    modport sink   (input valid, dot_value, row_pos, col_pos, out_addr, last_one, output ready);
endinterface

interface mgm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mgm_pkg::CFG_IDX_W-1:0]       index;
    logic [mgm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/masked_gram_matrix.sv -----
// Masked Gram matrix block, top level: configuration registers, column
// sequencer, two column stores and the shared MAC. Depends on mgm_pkg,
// mgm_if, mgm_ram and mgm_mac.
//
// Use: write the registers on cfg (always ready) while the block is idle. Send
// load requests on req to fill X and Y; each load is taken while idle and
// gives no result. A compute request forms X(:,i)' * Y(:,j) for every active
// X column i and active Y column j, Y column outer and X column inner, and
// offers each product on res with its ranks, col*stride+row and a flag on
// the final one. req is not ready from the compute request until the final
// result is taken.
// Timing: one store read and one MAC per element. Each pair clears the
// accumulator, reads its vec_length elements, drains the read, product and
// accumulate stages and then offers the result, which the receiver may
// stall; a zero length pair goes from the clear straight to the drain. A
// compute request with no active pair finishes in its accept cycle.
// Stall: a result holds on res until taken; the sequencer waits meanwhile.
// Reset: registers take their reset values and the sequencer goes idle; the
// stores are not cleared and must be written before they are read.
`default_nettype none

module masked_gram_matrix #(
    parameter int MAX_VECS = mgm_pkg::DEFAULT_MAX_VECS,
    parameter int MAX_LEN  = mgm_pkg::DEFAULT_MAX_LEN
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mgm_cfg_if.sink    cfg,
    mgm_req_if.sink    req,
    mgm_res_if.source  res
);

    // Vector and element index widths inside the stores
    localparam int VB = (MAX_VECS > 1) ? $clog2(MAX_VECS) : 1;
    localparam int LB = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DEPTH = 2 ** (VB + LB);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAIR  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } hit_t;

    // Lowest set bit of m at or above start
    function automatic hit_t find_from(input logic [7:0] m, input logic [3:0] start);
        hit_t h;
        h = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (m[i] && (4'(i) >= start))
            begin
                h.found = 1'b1;
                h.idx   = 3'(i);
            end
        end
        return h;
    endfunction

    // Configuration registers
    logic [8:0] vec_length_reg;
    logic [3:0] num_vecs_reg;
    logic [7:0] x_mask_reg;
    logic [7:0] y_mask_reg;
    logic [6:0] stride_reg;

    // Sequencer registers
    state_t                     state_reg, state_next;
    logic [VB-1:0]              xcol_reg, xcol_next;
    logic [VB-1:0]              ycol_reg, ycol_next;
    logic [mgm_pkg::POS_W-1:0]  row_reg, row_next;
    logic [mgm_pkg::POS_W-1:0]  col_reg, col_next;
    logic [LB-1:0]              k_reg, k_next;
    logic                       rd_v_reg;

    logic                       req_fire;
    logic                       issue;
    logic                       last_k;
    logic [31:0]                len_wide;
    logic [LW-1:0]              len_eff;
    logic [7:0]                 xm_eff;
    logic [7:0]                 ym_eff;
    hit_t                       fx, fy, nx, ny;

    // Store ports
    logic                       we_x, we_y;
    logic                       load_ok;
    logic [LB+7:0]              ei_ext;
    logic [VB+LB-1:0]           waddr;
    logic [mgm_pkg::ELEM_W-1:0] x_rdata, y_rdata;

    mgm_pkg::mac_ctl_t          mac_ctl;
    logic                       mac_busy;
    logic signed [mgm_pkg::DOT_W-1:0] acc;
    logic [10:0]                addr_full;

    // Configuration writes: always accepted, unknown index dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_length_reg <= mgm_pkg::RST_VEC_LENGTH;
            num_vecs_reg   <= mgm_pkg::RST_NUM_VECS;
            x_mask_reg     <= mgm_pkg::RST_X_MASK;
            y_mask_reg     <= mgm_pkg::RST_Y_MASK;
            stride_reg     <= mgm_pkg::RST_OUT_STRIDE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mgm_pkg::CFG_VEC_LENGTH: vec_length_reg <= cfg.data;
                mgm_pkg::CFG_NUM_VECS:   num_vecs_reg   <= cfg.data[3:0];
                mgm_pkg::CFG_X_MASK:     x_mask_reg     <= cfg.data[7:0];
                mgm_pkg::CFG_Y_MASK:     y_mask_reg     <= cfg.data[7:0];
                mgm_pkg::CFG_OUT_STRIDE: stride_reg     <= cfg.data[6:0];
                default:                 ;
            endcase
        end
    end

    // Saturate the length to the store depth
    assign len_wide = (32'(vec_length_reg) > 32'(MAX_LEN)) ? 32'(MAX_LEN) : 32'(vec_length_reg);
    assign len_eff  = len_wide[LW-1:0];

    // Drop mask bits of vectors beyond those in use
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            xm_eff[i] = x_mask_reg[i] && (i < MAX_VECS) && (4'(i) < num_vecs_reg);
            ym_eff[i] = y_mask_reg[i] && (i < MAX_VECS) && (4'(i) < num_vecs_reg);
        end
    end

    assign fx = find_from(xm_eff, 4'd0);
    assign fy = find_from(ym_eff, 4'd0);
    assign nx = find_from(xm_eff, 4'(xcol_reg) + 4'd1);
    assign ny = find_from(ym_eff, 4'(ycol_reg) + 4'd1);

    // Request side
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // Loads beyond the store bounds are dropped
    assign load_ok = ({29'd0, req.vec_index} < 32'(MAX_VECS))
                  && ({24'd0, req.elem_index} < 32'(MAX_LEN));
    assign ei_ext  = (LB + 8)'(req.elem_index);
    assign waddr   = {req.vec_index[VB-1:0], ei_ext[LB-1:0]};
    assign we_x    = req_fire && load_ok && (req.req_type == mgm_pkg::REQ_LOAD_X);
    assign we_y    = req_fire && load_ok && (req.req_type == mgm_pkg::REQ_LOAD_Y);

    mgm_ram #(
        .WIDTH (mgm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_x_store (
        .clk   (clk),
        .we    (we_x),
        .waddr (waddr),
        .wdata (req.elem_value),
        .raddr ({xcol_reg, k_reg}),
        .rdata (x_rdata)
    );

    mgm_ram #(
        .WIDTH (mgm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_y_store (
        .clk   (clk),
        .we    (we_y),
        .waddr (waddr),
        .wdata (req.elem_value),
        .raddr ({ycol_reg, k_reg}),
        .rdata (y_rdata)
    );

    // Sequencer: walk active Y columns outer, active X columns inner
    assign last_k = ((LW'(k_reg) + LW'(1)) == len_eff);
    assign issue  = (state_reg == ST_RUN);

    always_comb
    begin
        state_next    = state_reg;
        xcol_next     = xcol_reg;
        ycol_next     = ycol_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        mac_ctl.clear = 1'b0;
        mac_ctl.en    = rd_v_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // An empty mask on either side gives no result at all
                if (req_fire && (req.req_type == mgm_pkg::REQ_COMPUTE) && fx.found && fy.found)
                begin
                    xcol_next  = fx.idx[VB-1:0];
                    ycol_next  = fy.idx[VB-1:0];
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                mac_ctl.clear = 1'b1;
                k_next        = '0;
                // Zero length: skip straight to the cleared result
                state_next    = (len_eff == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + LB'(1);
                end
            end
            ST_DRAIN:
            begin
                // Hold until the read and product stages are empty
                if (!rd_v_reg && !mac_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res.ready)
                begin
                    if (nx.found)
                    begin
                        xcol_next  = nx.idx[VB-1:0];
                        row_next   = row_reg + 3'd1;
                        state_next = ST_PAIR;
                    end
                    else if (ny.found)
                    begin
                        ycol_next  = ny.idx[VB-1:0];
                        col_next   = col_reg + 3'd1;
                        xcol_next  = fx.idx[VB-1:0];
                        row_next   = '0;
                        state_next = ST_PAIR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        xcol_reg <= xcol_next;
        ycol_reg <= ycol_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        k_reg    <= k_next;
    end

    mgm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (x_rdata),
        .b     (y_rdata),
        .busy  (mac_busy),
        .acc   (acc)
    );

    // Result side: fields come straight from held registers
    assign addr_full     = 11'(col_reg) * 11'(stride_reg) + 11'(row_reg);
    assign res.valid     = (state_reg == ST_OUT);
    assign res.dot_value = acc;
    assign res.row_pos   = row_reg;
    assign res.col_pos   = col_reg;
    assign res.out_addr  = addr_full[8:0];
    assign res.last_one  = !nx.found && !ny.found;

endmodule

`default_nettype wire

// ----- src/mgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/mgm_mac.sv -----
// Shared multiply-accumulate unit: registered 32-bit Q2.30 product, then a 48-bit
// accumulator. Depends on mgm_pkg.
`default_nettype none

module mgm_mac (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mgm_pkg::mac_ctl_t                  ctl,
    input  wire logic signed [mgm_pkg::ELEM_W-1:0]  a,
    input  wire logic signed [mgm_pkg::ELEM_W-1:0]  b,
    output logic                                    busy,
    output logic signed [mgm_pkg::DOT_W-1:0]        acc
);

    logic signed [mgm_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_v_reg;
    logic signed [mgm_pkg::DOT_W-1:0]  acc_reg;
    logic signed [mgm_pkg::DOT_W-1:0]  acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + {{(mgm_pkg::DOT_W - mgm_pkg::PROD_W){prod_reg[mgm_pkg::PROD_W-1]}},
                                  prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctl.en && !ctl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign busy = prod_v_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire
